// ----- rtl/path_canonicalizer_defines.svh -----
// Assertion helpers shared by the path canonicaliser RTL.
// Each helper expands to a labelled concurrent assertion clocked on clock
// and disabled while reset is high; in synthesis the helpers expand to nothing.
`ifndef PATH_CANONICALIZER_DEFINES_SVH
`define PATH_CANONICALIZER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define PC_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define PC_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define PC_ASSERT_IMP(lbl, ante, cons, msg)
`define PC_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ----- rtl/pc_pkg.sv -----
`timescale 1ns / 1ps

package pc_pkg;

   localparam int BUF_BYTES_DEF = 256;

   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DOT   = 8'h2E;

   // Request kinds carried on req_tuser.
   typedef enum logic [1:0] {
      CMD_BYTE = 2'd0,
      CMD_END  = 2'd1,
      CMD_READ = 2'd2
   } cmd_type;

   // Where the returned byte comes from.
   typedef enum logic [1:0] {
      SRC_ZERO  = 2'd0,
      SRC_SLASH = 2'd1,
      SRC_MEM   = 2'd2
   } src_type;

   // Operation on the component-start stack; pop_n entries go, and a push is ignored when pop_n is non-zero.
   typedef struct packed {
      logic       push;
      logic [1:0] pop_n;
   } stk_op_type;

endpackage

// ----- rtl/pc_comp_stack.sv -----
`timescale 1ns / 1ps
`include "path_canonicalizer_defines.svh"

module pc_comp_stack import pc_pkg::*; #(
   parameter int BUF_BYTES = BUF_BYTES_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  stk_op_type                            op,
   input  logic [$clog2(BUF_BYTES)-1:0]          push_val,
   output logic [$clog2(BUF_BYTES/2+1)-1:0]      depth,
   output logic [$clog2(BUF_BYTES)-1:0]          top1,
   output logic [$clog2(BUF_BYTES)-1:0]          top2
);

   localparam int CW = $clog2(BUF_BYTES);
   localparam int SD = BUF_BYTES / 2;
   localparam int DW = $clog2(SD + 1);
   localparam int AW = $clog2(SD);

   logic [CW-1:0] stk_mem [SD];

   logic [DW-1:0] depth_ff, depth_in;
   logic [CW-1:0] t1_ff, t1_in, t2_ff, t2_in;
   logic [CW-1:0] rd1_ff, rd2_ff;
   logic          refill_ff, refill_in;
   logic [CW-1:0] t1_eff, t2_eff;
   logic          do_push, do_pop;
   logic [DW-1:0] depth_pop;
   logic [AW-1:0] rd1_addr, rd2_addr;

   // Top two entries live in flops; after a pop they are reloaded from memory.
   assign t1_eff = refill_ff ? rd1_ff : t1_ff;
   assign t2_eff = refill_ff ? rd2_ff : t2_ff;

   always_comb begin
      do_push   = op.push && (depth_ff < DW'(SD));
      do_pop    = (op.pop_n != 2'd0);
      depth_pop = depth_ff - DW'(op.pop_n);
      rd1_addr  = '0;
      rd2_addr  = '0;
      if (depth_pop >= DW'(1)) begin
         rd1_addr = AW'(depth_pop - DW'(1));
      end
      if (depth_pop >= DW'(2)) begin
         rd2_addr = AW'(depth_pop - DW'(2));
      end
      depth_in  = depth_ff;
      refill_in = 1'b0;
      t1_in     = t1_eff;
      t2_in     = t2_eff;
      if (do_pop) begin
         depth_in  = depth_pop;
         refill_in = 1'b1;
      end else if (do_push) begin
         depth_in = depth_ff + DW'(1);
         t1_in    = push_val;
         t2_in    = t1_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff  <= '0;
         refill_ff <= 1'b0;
      end else begin
         depth_ff  <= depth_in;
         refill_ff <= refill_in;
      end
   end

   always_ff @(posedge clock) begin
      t1_ff <= t1_in;
      t2_ff <= t2_in;
   end

   always_ff @(posedge clock) begin
      if (do_push && !do_pop) begin
         stk_mem[depth_ff[AW-1:0]] <= push_val;
      end
      if (do_pop) begin
         rd1_ff <= stk_mem[rd1_addr];
         rd2_ff <= stk_mem[rd2_addr];
      end
   end

   assign depth = depth_ff;
   assign top1  = t1_eff;
   assign top2  = t2_eff;

   `PC_ASSERT_IMP(a_no_pop_in_refill, refill_ff, op.pop_n == 2'd0, "pop while top reloads")
   `PC_ASSERT_IMP(a_pop_within_depth, op.pop_n != 2'd0, DW'(op.pop_n) <= depth_ff, "pop below empty")
   `PC_ASSERT_NXT(a_push_lands_on_top, do_push && !do_pop, t1_eff == $past(push_val), "push lost")

endmodule

// ----- rtl/path_canonicalizer.sv -----
`timescale 1ns / 1ps
`include "path_canonicalizer_defines.svh"

// Streaming absolute-path canonicaliser.
// Input channel req_*: one word per command. req_tuser carries the command
// (path byte, end of path, read output byte); req_tdata carries the path byte
// and the read index. Output channel rsp_*: exactly one word per input word,
// in order, carrying the byte read (zero for non-read commands), the length
// of the canonical path so far and the done flag.
// A response passes through the registered read of the output byte store
// and then the output register before it appears. Throughput: one word per
// cycle, sustained while rsp_tready stays high; every command needs at most
// one write or one read of the byte store plus at most one stack access.
// Held-back dot bytes are written ahead into the store beyond the committed
// length, so each word needs only one store write port and one read port.
// Reset clears the length, stack depth, flags and both pipeline valids; the
// stores need no clearing pass and the block takes words straight away.
// A stalled receiver holds the output register; one more word is still taken
// into the read stage, after which req_tready drops until rsp_tready returns.
module path_canonicalizer import pc_pkg::*; #(
   parameter int BUF_BYTES = BUF_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] path_byte, [15:8] read_index
   input  logic [1:0]  req_tuser,   // [1:0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] read_byte, [15:8] result_length,
                                    // [16] path_done, [23:17] zero
);

   localparam int CW = $clog2(BUF_BYTES);
   localparam int SD = BUF_BYTES / 2;
   localparam int DW = $clog2(SD + 1);
   localparam int XW = CW + 2;
   localparam logic [XW-1:0] LIMIT = XW'(BUF_BYTES - 1);

   // Canonical output bytes; entry 0 is always '/' and is never stored.
   logic [7:0] store_mem [BUF_BYTES];

   // Architectural state.
   logic [CW-1:0] count_ff, count_in;
   logic          last_slash_ff, last_slash_in;
   logic [1:0]    comp_len_ff, comp_len_in;   // 3: component being streamed
   logic          seen_ff, seen_in;
   logic          done_ff, done_in;

   // Pipeline: read stage then output register.
   logic          s1_v_ff, s1_v_in;
   logic [7:0]    s1_len_ff;
   logic          s1_done_ff;
   src_type       s1_src_ff;
   logic [7:0]    rd_byte_ff;
   logic          out_v_ff, out_v_in;
   logic [23:0]   out_data_ff;

   logic          accept, s1_adv;
   cmd_type       cmd;
   logic [7:0]    pb, idx;

   logic [XW-1:0] cnt, base, sum, grown, wr_addr, pop_cnt;
   logic          lslash, room, sep, pop_req, dang;
   logic [DW-1:0] stk_depth, d1;
   logic [CW-1:0] top1, top2, pop_pos, push_val;
   stk_op_type    stk_op;
   logic          wr_en;
   logic [7:0]    wr_data;

   logic [CW+7:0] idx_ext, cnt_ext, len_ext;
   logic          rd_hit, rd_en;
   src_type       src_in;
   logic [7:0]    rsp_byte;

   assign cmd = cmd_type'(req_tuser);
   assign pb  = req_tdata[7:0];
   assign idx = req_tdata[15:8];

   // Advance the read stage when the output register is free or draining.
   assign s1_adv     = s1_v_ff && (!out_v_ff || rsp_tready);
   assign req_tready = !s1_v_ff || s1_adv;
   assign accept     = req_tvalid && req_tready;
   assign s1_v_in    = accept || (s1_v_ff && !s1_adv);
   assign out_v_in   = s1_adv || (out_v_ff && !rsp_tready);

   // Before the first byte the path counts as just the root slash.
   assign cnt    = seen_ff ? XW'(count_ff) : XW'(1);
   assign lslash = seen_ff ? last_slash_ff : 1'b1;
   assign room   = cnt < LIMIT;
   // A separator is due when the last stored byte is a component byte.
   assign sep    = (cnt > XW'(1)) && !lslash && room;
   assign base   = cnt + XW'(sep);
   assign sum    = base + XW'(comp_len_ff) + XW'(1);
   assign grown  = (sum > LIMIT) ? LIMIT : sum;

   // '..' pop: a dangling separator goes together with the component before it.
   assign dang    = lslash && (stk_depth != '0);
   assign d1      = stk_depth - DW'(dang);
   assign pop_pos = dang ? top2 : top1;
   assign pop_cnt = ((pop_pos != '0) && (XW'(pop_pos) < cnt)) ? XW'(pop_pos) : XW'(1);

   always_comb begin
      count_in      = count_ff;
      last_slash_in = last_slash_ff;
      comp_len_in   = comp_len_ff;
      seen_in       = seen_ff;
      done_in       = done_ff;
      wr_en         = 1'b0;
      wr_addr       = cnt;
      wr_data       = CH_SLASH;
      pop_req       = 1'b0;
      stk_op        = '0;
      push_val      = '0;
      case (cmd)
         CMD_BYTE: begin
            if (!done_ff) begin
               seen_in       = 1'b1;
               count_in      = CW'(cnt);
               last_slash_in = lslash;
               wr_en         = 1'b1;
               if (pb == CH_SLASH) begin
                  // Stage a separator at the tail; it stays beyond the length.
                  pop_req     = (comp_len_ff == 2'd2);
                  comp_len_in = 2'd0;
                  wr_addr     = cnt;
                  wr_data     = CH_SLASH;
               end else if ((comp_len_ff < 2'd2) && (pb == CH_DOT)) begin
                  // Hold the dot back but write it ahead of the length.
                  wr_addr     = base + XW'(comp_len_ff);
                  wr_data     = CH_DOT;
                  comp_len_in = comp_len_ff + 2'd1;
               end else if (comp_len_ff != 2'd3) begin
                  // Start a component: commit separator, held dots and byte.
                  if (cnt == XW'(1)) begin
                     stk_op.push = 1'b1;
                     push_val    = '0;
                  end else if (sep) begin
                     stk_op.push = 1'b1;
                     push_val    = CW'(cnt);
                  end
                  wr_addr     = base + XW'(comp_len_ff);
                  wr_data     = pb;
                  comp_len_in = 2'd3;
                  if (room) begin
                     count_in      = CW'(grown);
                     last_slash_in = sep && (grown == cnt + XW'(1));
                  end
               end else begin
                  wr_addr = cnt;
                  wr_data = pb;
                  if (room) begin
                     count_in      = CW'(cnt + XW'(1));
                     last_slash_in = 1'b0;
                  end
               end
            end
         end
         CMD_END: begin
            if (!done_ff) begin
               pop_req     = (comp_len_ff == 2'd2);
               comp_len_in = 2'd0;
               done_in     = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (pop_req && (cnt > XW'(1))) begin
         if (d1 == '0) begin
            stk_op.pop_n  = 2'(stk_depth);
            count_in      = CW'(1);
            last_slash_in = 1'b1;
         end else begin
            stk_op.pop_n  = {1'b0, dang} + 2'd1;
            count_in      = CW'(pop_cnt);
            last_slash_in = (pop_cnt == XW'(1));
         end
      end
      if (!accept) begin
         stk_op = '0;
         wr_en  = 1'b0;
      end
   end

   pc_comp_stack #(
      .BUF_BYTES (BUF_BYTES)
   ) u_comp_stack (
      .clock    (clock),
      .reset    (reset),
      .op       (stk_op),
      .push_val (push_val),
      .depth    (stk_depth),
      .top1     (top1),
      .top2     (top2)
   );

   // Read command: index 0 is the root slash once a byte is taken, beyond the length reads zero.
   assign idx_ext = {{CW{1'b0}}, idx};
   assign cnt_ext = {8'b0, count_ff};
   assign len_ext = {8'b0, count_in};
   assign rd_hit  = idx_ext < cnt_ext;
   assign rd_en   = accept && (cmd == CMD_READ) && rd_hit && (idx != 8'd0);

   always_comb begin
      src_in = SRC_ZERO;
      if ((cmd == CMD_READ) && rd_hit) begin
         src_in = (idx == 8'd0) ? SRC_SLASH : SRC_MEM;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && (wr_addr < XW'(BUF_BYTES))) begin
         store_mem[wr_addr[CW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_byte_ff <= store_mem[idx_ext[CW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         last_slash_ff <= 1'b0;
         comp_len_ff   <= 2'd0;
         seen_ff       <= 1'b0;
         done_ff       <= 1'b0;
         s1_v_ff       <= 1'b0;
         out_v_ff      <= 1'b0;
      end else begin
         if (accept) begin
            count_ff      <= count_in;
            last_slash_ff <= last_slash_in;
            comp_len_ff   <= comp_len_in;
            seen_ff       <= seen_in;
            done_ff       <= done_in;
         end
         s1_v_ff  <= s1_v_in;
         out_v_ff <= out_v_in;
      end
   end

   always_comb begin
      case (s1_src_ff)
         SRC_SLASH: rsp_byte = CH_SLASH;
         SRC_MEM:   rsp_byte = rd_byte_ff;
         default:   rsp_byte = 8'd0;
      endcase
   end

   // Hold the read stage and output register while they cannot advance.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_len_ff  <= len_ext[7:0];
         s1_done_ff <= done_in;
         s1_src_ff  <= src_in;
      end
      if (s1_adv) begin
         out_data_ff <= {7'b0, s1_done_ff, s1_len_ff, rsp_byte};
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;

   `PC_ASSERT_NXT(a_done_freezes_len, done_ff, count_ff == $past(count_ff), "length moved after end")
   `PC_ASSERT_IMP(a_root_is_slash, count_ff == CW'(1), last_slash_ff, "root not marked as slash")
   `PC_ASSERT_IMP(a_depth_le_len, 1'b1, XW'(stk_depth) <= XW'(count_ff), "stack deeper than path")
   `PC_ASSERT_IMP(a_comp_needs_seen, comp_len_ff != 2'd0, seen_ff, "component without a byte")

endmodule
